// ===== sv/nws_pkg.sv =====
// ----------------------------------------------------------------------------
// nws_pkg
// shared constants, codes and the sigmoid breakpoint table of the neuron
// ----------------------------------------------------------------------------
package nws_pkg;

    localparam int ADDR_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BIAS_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int OUT_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic MODE_STEP    = 1'b0;
    localparam logic MODE_SIGMOID = 1'b1;

    localparam logic [OUT_W-1:0] ONE_Q15 = 16'h8000;

    // 32768 * sigmoid(k), last point forced to 1.0
    function automatic logic [OUT_W-1:0] sig_point(input logic [3:0] k);
        logic [OUT_W-1:0] v;
        unique case (k)
            4'd0:    v = 16'd16384;
            4'd1:    v = 16'd23955;
            4'd2:    v = 16'd28862;
            4'd3:    v = 16'd31214;
            4'd4:    v = 16'd32179;
            4'd5:    v = 16'd32549;
            4'd6:    v = 16'd32687;
            4'd7:    v = 16'd32738;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/nws_ram.sv =====
// ----------------------------------------------------------------------------
// nws_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module nws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/nws_mac.sv =====
// ----------------------------------------------------------------------------
// nws_mac
// weight store, sample index, multiply stage and accumulator
// ----------------------------------------------------------------------------
module nws_mac #(
    parameter int DATA_WIDTH = 16,
    parameter int MAX_INPUTS = 64,
    parameter int ACC_W      = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [nws_pkg::ADDR_W-1:0]          i_weight_addr,
    input  logic signed [DATA_WIDTH-1:0]        i_data_value,
    input  logic signed [nws_pkg::BIAS_W-1:0]   i_bias,
    input  logic [nws_pkg::COUNT_W-1:0]         i_count,
    output logic                                o_sum_valid,
    input  logic                                i_sum_ready,
    output logic signed [ACC_W-1:0]             o_sum
);
    import nws_pkg::*;

    localparam int AW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int PROD_W = 2 * DATA_WIDTH;

    logic                          accept;
    logic                          is_sample;
    logic [31:0]                   count_raw;
    logic [31:0]                   count_eff;
    logic [31:0]                   waddr_ext;
    logic                          wr_en;
    logic                          last_in;
    logic [DATA_WIDTH-1:0]         weight;

    logic [AW-1:0]                 r_idx;
    logic [AW-1:0]                 n_idx;

    logic                          r_v1;
    logic signed [DATA_WIDTH-1:0]  r_data1;
    logic                          r_first1;
    logic                          r_last1;
    logic                          r_v2;
    logic signed [PROD_W-1:0]      r_prod2;
    logic                          r_first2;
    logic                          r_last2;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_sv;
    logic signed [ACC_W-1:0]       r_sum;

    logic                          rdy_sum;
    logic                          adv2;
    logic                          rdy2;
    logic                          adv1;
    logic signed [ACC_W-1:0]       bias_acc;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       n_acc;

    assign rdy_sum   = !r_sv || i_sum_ready;
    assign adv2      = r_v2 && (!r_last2 || rdy_sum);
    assign rdy2      = !r_v2 || adv2;
    assign adv1      = r_v1 && rdy2;
    assign o_ready   = !r_v1 || adv1;
    assign accept    = i_valid && o_ready;
    assign is_sample = (i_cmd == CMD_SAMPLE);

    // count of zero acts as one, above the store depth acts as the depth
    assign count_raw = 32'(i_count);
    always_comb begin
        count_eff = count_raw;
        if (count_raw == 32'd0) begin
            count_eff = 32'd1;
        end else if (count_raw > 32'(MAX_INPUTS)) begin
            count_eff = 32'(MAX_INPUTS);
        end
    end

    assign last_in   = (32'(r_idx) + 32'd1) >= count_eff;
    assign n_idx     = last_in ? '0 : AW'(32'(r_idx) + 32'd1);
    assign waddr_ext = 32'(i_weight_addr);
    assign wr_en     = accept && !is_sample && (waddr_ext < 32'(MAX_INPUTS));

    nws_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_INPUTS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (i_data_value),
        .i_re    (accept && is_sample),
        .i_raddr (r_idx),
        .o_rdata (weight)
    );

    assign bias_acc = ACC_W'({{(ACC_W-BIAS_W){i_bias[BIAS_W-1]}}, i_bias}) <<< 8;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod2[PROD_W-1]}}, r_prod2};
    assign n_acc    = (r_first2 ? bias_acc : r_acc) + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_sv  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (o_ready) begin
                r_v1 <= accept && is_sample;
            end
            if (accept && is_sample) begin
                r_idx    <= n_idx;
                r_data1  <= i_data_value;
                r_first1 <= (r_idx == '0);
                r_last1  <= last_in;
            end
            if (rdy2) begin
                r_v2 <= adv1;
            end
            if (adv1) begin
                r_prod2  <= r_data1 * $signed(weight);
                r_first2 <= r_first1;
                r_last2  <= r_last1;
            end
            if (adv2) begin
                r_acc <= r_last2 ? '0 : n_acc;
            end
            if (rdy_sum) begin
                r_sv <= adv2 && r_last2;
            end
            if (adv2 && r_last2) begin
                r_sum <= n_acc;
            end
        end
    end

    assign o_sum_valid = r_sv;
    assign o_sum       = r_sum;

endmodule

// ===== sv/nws_act.sv =====
// ----------------------------------------------------------------------------
// nws_act
// step or piecewise-linear sigmoid activation, three register stages
// ----------------------------------------------------------------------------
module nws_act #(
    parameter int ACC_W = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ACC_W-1:0]       i_sum,
    input  logic                          i_mode,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nws_pkg::OUT_W-1:0]     o_neuron_out
);
    import nws_pkg::*;

    typedef struct packed {
        logic neg;
        logic sat;
        logic pos;
        logic mode;
    } t_act_ctl;

    logic                 neg;
    logic [ACC_W-1:0]     mag;
    logic [2:0]           k;
    logic [OUT_W-1:0]     lo;
    logic [OUT_W-1:0]     hi;
    t_act_ctl             ctl;

    logic                 r_va;
    t_act_ctl             r_ctl_a;
    logic [OUT_W-1:0]     r_lo_a;
    logic [OUT_W-1:0]     r_diff_a;
    logic [15:0]          r_f_a;
    logic                 r_vb;
    t_act_ctl             r_ctl_b;
    logic [OUT_W-1:0]     r_lo_b;
    logic [31:0]          r_interp_b;
    logic                 r_vo;
    logic [OUT_W-1:0]     r_out;

    logic                 rdy_o;
    logic                 rdy_b;
    logic [OUT_W-1:0]     y;
    logic [OUT_W-1:0]     n_out;

    assign rdy_o   = !r_vo || i_ready;
    assign rdy_b   = !r_vb || rdy_o;
    assign o_ready = !r_va || rdy_b;

    assign neg      = i_sum[ACC_W-1];
    assign mag      = neg ? (~i_sum + 1'b1) : i_sum;
    assign k        = mag[18:16];
    assign lo       = sig_point({1'b0, k});
    assign hi       = sig_point(4'({1'b0, k}) + 4'd1);
    assign ctl.neg  = neg;
    assign ctl.sat  = |mag[ACC_W-1:19];
    assign ctl.pos  = !neg && (i_sum != '0);
    assign ctl.mode = i_mode;

    always_comb begin
        y = r_lo_b + r_interp_b[31:16];
        if (r_ctl_b.sat) begin
            y = ONE_Q15;
        end
        if (r_ctl_b.mode == MODE_STEP) begin
            n_out = r_ctl_b.pos ? ONE_Q15 : '0;
        end else begin
            n_out = r_ctl_b.neg ? (ONE_Q15 - y) : y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (o_ready) begin
                r_va <= i_valid;
            end
            if (i_valid && o_ready) begin
                r_ctl_a  <= ctl;
                r_lo_a   <= lo;
                r_diff_a <= hi - lo;
                r_f_a    <= mag[15:0];
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (r_va && rdy_b) begin
                r_ctl_b    <= r_ctl_a;
                r_lo_b     <= r_lo_a;
                r_interp_b <= 32'(r_diff_a) * 32'(r_f_a) + 32'd32768;
            end
            if (rdy_o) begin
                r_vo <= r_vb;
            end
            if (r_vb && rdy_o) begin
                r_out <= n_out;
            end
        end
    end

    assign o_valid      = r_vo;
    assign o_neuron_out = r_out;

endmodule

// ===== sv/neuron_weighted_sum_activation.sv =====
// ----------------------------------------------------------------------------
// neuron_weighted_sum_activation
// single neuron: weighted sum of samples plus bias, step or sigmoid output
// ----------------------------------------------------------------------------
// input channel (i_valid / o_ready): a transaction with i_cmd = write stores
// i_data_value at i_weight_addr in the weight ram; one with i_cmd = sample
// multiplies i_data_value by the weight at the running sample index and adds
// it to the sum, which starts from the bias (q8.8, entered as q16.16).
// after input_count samples one result leaves on the output channel
// (o_valid / i_ready) as q1.15, 32768 meaning 1.0.
// configuration: i_cfg_we writes register i_cfg_idx (bias, mode, count)
// in the same cycle; write it only while the block is idle.
// throughput: one transaction per cycle while o_ready stays high, set by the
// single multiply stage and the accumulator register. pipeline: six register
// stages follow the edge that accepts the last sample: input and ram read,
// multiply, accumulate, classify, interpolation multiply, output. reset clears
// all valid flags, the index, the accumulator and the config registers;
// weights are undefined until written. while the receiver stalls, results
// queue in the activation stages; samples keep being accepted until a final
// sample finds no free stage, then o_ready drops.
// ----------------------------------------------------------------------------
module neuron_weighted_sum_activation #(
    parameter int DATA_WIDTH = 16,
    parameter int MAX_INPUTS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic [nws_pkg::ADDR_W-1:0]           i_weight_addr,
    input  logic signed [DATA_WIDTH-1:0]         i_data_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [nws_pkg::OUT_W-1:0]            o_neuron_out,
    input  logic                                 i_cfg_we,
    input  logic [nws_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [nws_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import nws_pkg::*;

    localparam int LOG_N   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 0;
    localparam int ACC_RAW = 2 * DATA_WIDTH + LOG_N + 2;
    localparam int ACC_W   = (ACC_RAW > 26) ? ACC_RAW : 26;

    logic signed [BIAS_W-1:0]  r_bias;
    logic                      r_mode;
    logic [COUNT_W-1:0]        r_count;

    logic                      sum_valid;
    logic                      sum_ready;
    logic signed [ACC_W-1:0]   sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= '0;
            r_mode  <= MODE_STEP;
            r_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIAS:  r_bias  <= i_cfg_wdata[BIAS_W-1:0];
                CFG_MODE:  r_mode  <= i_cfg_wdata[0];
                CFG_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    nws_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_INPUTS (MAX_INPUTS),
        .ACC_W      (ACC_W)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_weight_addr (i_weight_addr),
        .i_data_value  (i_data_value),
        .i_bias        (r_bias),
        .i_count       (r_count),
        .o_sum_valid   (sum_valid),
        .i_sum_ready   (sum_ready),
        .o_sum         (sum)
    );

    nws_act #(
        .ACC_W (ACC_W)
    ) u_act (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (sum_valid),
        .o_ready      (sum_ready),
        .i_sum        (sum),
        .i_mode       (r_mode),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_neuron_out (o_neuron_out)
    );

    // result never above 1.0
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_neuron_out <= ONE_Q15))
        else $error("activation result above one");

    // pipeline empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("pipeline not empty after reset");

    // input never stalls while no sum waits for the activation stages
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sum_valid |-> o_ready)
        else $error("unexpected input stall");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neuron_weighted_sum_activation testbench
// streams weight writes and samples into the neuron with random idling on
// both channels, predicts each activation result from its own copy of the
// weights, sum and registers, and checks every output transaction in order
// across a series of register settings, extremes included
// ----------------------------------------------------------------------------
module testbench;
    import nws_pkg::*;

    localparam int N_WEIGHTS   = 64;
    localparam int DRAIN_WAIT  = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1040;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } t_neuron_txn;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_cmd = CMD_WRITE;
    logic [ADDR_W-1:0]     i_weight_addr = '0;
    logic signed [15:0]    i_data_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [OUT_W-1:0]      o_neuron_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_BIAS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // 32768 * sigmoid(k), last knot pinned to 1.0
    logic [15:0] sig_knots [0:8] = '{16'd16384, 16'd23955, 16'd28862, 16'd31214,
                                     16'd32179, 16'd32549, 16'd32687, 16'd32738,
                                     16'd32768};

    t_neuron_txn      txn_backlog [$];
    logic [OUT_W-1:0] neuron_out_q [$];

    // stimulus view of the sample index, to keep unwritten weights unread
    int unsigned gen_idx = 0;
    int unsigned gen_count = 1;
    bit          gen_written [N_WEIGHTS];

    logic signed [15:0]  wt_mirror [N_WEIGHTS];
    logic signed [63:0]  sum_acc = '0;
    int unsigned         smp_idx = 0;
    logic signed [15:0]  bias_reg = '0;
    logic                mode_reg = MODE_STEP;
    logic [COUNT_W-1:0]  count_reg = 7'd1;

    int n_queued = 0;
    int n_accepted = 0;
    int n_writes = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_settings = 0;
    int n_errors = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit send_idle = 1'b0;
    bit rcv_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    neuron_weighted_sum_activation #(
        .DATA_WIDTH(16),
        .MAX_INPUTS(N_WEIGHTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_weight_addr (i_weight_addr),
        .i_data_value  (i_data_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_neuron_out  (o_neuron_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rand_q88();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                3: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        if (r < 35) return 16'($urandom_range(0, 128)) - 16'd64;
        if (r < 85) return 16'($urandom_range(0, 1024)) - 16'd512;
        return 16'($urandom);
    endfunction

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic int unsigned eff_count(input logic [COUNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > N_WEIGHTS) return N_WEIGHTS;
        return c;
    endfunction

    function automatic logic [OUT_W-1:0] activation_of(input logic signed [63:0] s,
                                                      input logic mode);
        logic [63:0] mag;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] y;
        int unsigned k;
        if (mode == MODE_STEP) return (s > 0) ? ONE_Q15 : 16'd0;
        mag = s[63] ? -s : s;
        if (mag >= 64'h80000) begin
            y = 32'd32768;
        end else begin
            k  = mag[19:16];
            lo = sig_knots[k];
            hi = sig_knots[k + 1];
            y  = lo + (((hi - lo) * mag[15:0] + 32'd32768) >> 16);
        end
        if (s[63]) y = 32'd32768 - y;
        return y[15:0];
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic queue_write(input logic [ADDR_W-1:0] a, input logic [15:0] d);
        t_neuron_txn t;
        t.cmd  = CMD_WRITE;
        t.addr = a;
        t.data = d;
        txn_backlog.push_back(t);
        gen_written[a] = 1'b1;
        n_queued++;
    endtask

    task automatic queue_sample(input logic [15:0] d);
        t_neuron_txn t;
        if (!gen_written[gen_idx]) queue_write(gen_idx[ADDR_W-1:0], rand_q88());
        t.cmd  = CMD_SAMPLE;
        t.addr = 6'($urandom);
        t.data = d;
        txn_backlog.push_back(t);
        n_queued++;
        gen_idx = (gen_idx + 1 >= gen_count) ? 0 : gen_idx + 1;
    endtask

    task automatic program_neuron(input logic [15:0] b, input logic m,
                                  input logic [COUNT_W-1:0] c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BIAS;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MODE;
        i_cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, m};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_COUNT;
        i_cfg_wdata <= {{(CFG_DATA_W-COUNT_W){1'b0}}, c};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_count = eff_count(c);
        n_settings++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || neuron_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        t_neuron_txn t;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (txn_backlog.size() > 0) begin
                t = txn_backlog.pop_front();
                i_valid       <= 1'b1;
                i_cmd         <= t.cmd;
                i_weight_addr <= t.addr;
                i_data_value  <= t.data;
                gap_left      <= (send_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (rcv_idle && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_len() - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // checks outputs, mirrors register and weight writes, then folds samples into the sum
    always @(posedge i_clk) begin : monitor
        logic [OUT_W-1:0]   want;
        logic signed [31:0] prod;
        if (!i_rst_n) begin
            sum_acc   = '0;
            smp_idx   = 0;
            bias_reg  = '0;
            mode_reg  = MODE_STEP;
            count_reg = 7'd1;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (neuron_out_q.size() == 0) begin
                    note_error($sformatf("unexpected result neuron_out=%0d", o_neuron_out));
                end else begin
                    want = neuron_out_q.pop_front();
                    if (o_neuron_out !== want)
                        note_error($sformatf("neuron_out expected %0d got %0d",
                                             want, o_neuron_out));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIAS:  bias_reg  = i_cfg_wdata[BIAS_W-1:0];
                    CFG_MODE:  mode_reg  = i_cfg_wdata[0];
                    CFG_COUNT: count_reg = i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                n_accepted++;
                if (i_cmd == CMD_WRITE) begin
                    wt_mirror[i_weight_addr] = i_data_value;
                    n_writes++;
                end else begin
                    n_samples++;
                    if (smp_idx == 0) sum_acc = {{40{bias_reg[15]}}, bias_reg, 8'd0};
                    prod    = i_data_value * wt_mirror[smp_idx];
                    sum_acc = sum_acc + prod;
                    smp_idx++;
                    if (smp_idx >= eff_count(count_reg)) begin
                        neuron_out_q.push_back(activation_of(sum_acc, mode_reg));
                        sum_acc = '0;
                        smp_idx = 0;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned c;
        int unsigned r;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step: zero sum, signs, largest products
        program_neuron(16'h0000, MODE_STEP, 7'd1);
        queue_write(6'd0, 16'h0100);
        queue_sample(16'h0000);
        queue_sample(16'h0001);
        queue_sample(16'hffff);
        queue_write(6'd0, 16'h8000);
        queue_sample(16'h8000);
        queue_sample(16'h7fff);
        drain();
        // saturation from the bias alone, zero count behaves as one
        program_neuron(16'h7fff, MODE_SIGMOID, 7'd0);
        queue_write(6'd0, 16'h0000);
        queue_sample(16'h1234);
        drain();
        // sum of exactly -8.0, then a weight rewritten part-way through a sum
        program_neuron(16'hf800, MODE_SIGMOID, 7'd2);
        queue_write(6'd1, 16'h0000);
        queue_sample(16'h0005);
        queue_sample(16'h7fff);
        queue_sample(16'h0005);
        queue_write(6'd1, 16'h0100);
        queue_sample(16'h0100);
        drain();
        // sum of exactly +8.0
        program_neuron(16'h0800, MODE_SIGMOID, 7'd1);
        queue_write(6'd0, 16'h0000);
        queue_sample(16'h4321);
        drain();
        // interpolation and the midpoint
        program_neuron(16'h0180, MODE_SIGMOID, 7'd1);
        queue_sample(16'hbeef);
        queue_write(6'd0, 16'h0100);
        queue_sample(16'hff00);
        queue_sample(16'hfe80);
        drain();
        // registers rewritten between samples of one evaluation
        program_neuron(16'h0040, MODE_STEP, 7'd3);
        queue_sample(rand_q88());
        queue_sample(rand_q88());
        drain();
        program_neuron(16'h8000, MODE_SIGMOID, 7'd2);
        queue_sample(rand_q88());
        drain();

        // receiver held off while samples arrive at full rate
        program_neuron(rand_q88(), MODE_SIGMOID, 7'd1);
        send_idle = 1'b0;
        rcv_idle  = 1'b0;
        hold_req  = 1'b1;
        repeat (120) queue_sample(rand_q88());
        drain();

        while (n_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                c = $urandom_range(1, 8);
            end else if (r < 85) begin
                c = $urandom_range(9, 20);
            end else begin
                case ($urandom_range(0, 3))
                    0: c = 0;
                    1: c = 64;
                    2: c = 65;
                    default: c = 127;
                endcase
            end
            send_idle = $urandom_range(0, 3) != 0;
            rcv_idle  = $urandom_range(0, 3) != 0;
            program_neuron(rand_q88(),
                           ($urandom_range(0, 1) != 0) ? MODE_SIGMOID : MODE_STEP, 7'(c));
            len = (gen_count > 8) ? 2 * gen_count + $urandom_range(0, 20)
                                  : $urandom_range(20, 70);
            repeat (len) begin
                if ($urandom_range(0, 99) < 75) queue_sample(rand_q88());
                else queue_write(6'($urandom), rand_q88());
            end
            drain();
        end

        while (n_accepted != n_queued) @(posedge i_clk);
        for (int w = 0; w < 4000 && neuron_out_q.size() != 0; w++) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (neuron_out_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", neuron_out_q.size()));
        $display("%0d transactions in (%0d weight writes, %0d samples) over %0d settings",
                 n_accepted, n_writes, n_samples, n_settings);
        $display("%0d results checked, %0d mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
